FILE: design/scc_pkg.sv
// scc_pkg: shared constants, state codes and word types for the strongly
// connected components block
// no dependencies
package scc_pkg;

    localparam int MAX_V = 64;
    localparam int MAX_E = 256;
    localparam int VW    = $clog2(MAX_V);
    localparam int EW    = $clog2(MAX_E);
    localparam int CNTW  = VW + 1;
    localparam int ECW   = EW + 1;
    localparam int SSW   = VW + ECW;

    localparam logic [CNTW-1:0] NV_MAX = CNTW'(MAX_V);
    localparam logic [ECW-1:0]  NE_MAX = ECW'(MAX_E);

    typedef enum logic [13:0] {
        S_IDLE = 14'b00000000000001,
        S_ROOT = 14'b00000000000010,
        S_ENT0 = 14'b00000000000100,
        S_ENT1 = 14'b00000000001000,
        S_TOP  = 14'b00000000010000,
        S_EDGE = 14'b00000000100000,
        S_VISW = 14'b00000001000000,
        S_FIN  = 14'b00000010000000,
        S_POP0 = 14'b00000100000000,
        S_POP1 = 14'b00001000000000,
        S_RET0 = 14'b00010000000000,
        S_RET1 = 14'b00100000000000,
        S_RET2 = 14'b01000000000000,
        S_END  = 14'b10000000000000
    } t_state;

    typedef struct packed {
        logic [VW-1:0] vertex;
        logic [VW-1:0] position;
        logic [VW-1:0] component_number;
        logic          component_end;
    } t_result;

    typedef struct packed {
        logic    push;
        logic    last;
        t_result res;
    } t_emit;

endpackage

FILE: design/scc_ram.sv
// scc_ram: generic simple dual-port ram, one write and one registered read
// no dependencies
module scc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

FILE: design/scc_core.sv
// scc_core: edge store and depth-first search sequencer over shared rams
// depends on scc_pkg and scc_ram
module scc_core import scc_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic            i_cmd,
    input  logic [VW-1:0]   i_edge_source,
    input  logic [VW-1:0]   i_edge_target,
    input  logic [CNTW-1:0] i_vcount,
    input  logic            i_out_free,
    output t_emit           o_emit
);
    t_state          r_state;
    logic [ECW-1:0]  r_edges;
    logic [VW-1:0]   r_last_src;
    logic [MAX_V-1:0] r_fvalid, r_visited, r_onstk;
    logic [CNTW-1:0] r_root, r_sdepth, r_cdepth, r_nv, r_pos, r_comp;
    logic [CNTW-1:0] r_vis, r_low;
    logic [VW-1:0]   r_v, r_cv;
    logic [ECW-1:0]  r_e;
    logic            r_hvalid;
    t_result         r_hold;

    logic [CNTW-1:0] n;
    logic            acc, ld_ok, new_first;
    logic [2*VW-1:0] e_rd;
    logic [VW-1:0]   e_src, e_dst;
    logic [EW-1:0]   f_rd;
    logic [CNTW-1:0] vis_rd, low_rd;
    logic [VW-1:0]   cs_rd;
    logic [SSW-1:0]  ss_rd;
    logic [VW-1:0]   pv;
    logic [CNTW-1:0] c_idx, s_top, s_par;
    logic            descend, pop_go, end_go;
    logic [VW-1:0]   vis_raddr, low_waddr;
    logic [CNTW-1:0] low_wdata;
    logic [ECW-1:0]  cursor;

    assign n         = (i_vcount > NV_MAX) ? NV_MAX : i_vcount;
    assign o_ready   = (r_state == S_IDLE);
    assign acc       = i_valid && o_ready;
    assign ld_ok     = (r_edges < NE_MAX) && ({1'b0, i_edge_source} < n)
                       && ({1'b0, i_edge_target} < n)
                       && !((r_edges != '0) && (i_edge_source < r_last_src));
    assign new_first = (r_edges == '0) || (i_edge_source != r_last_src);

    assign e_src   = e_rd[2*VW-1:VW];
    assign e_dst   = e_rd[VW-1:0];
    assign pv      = ss_rd[SSW-1:ECW];
    assign c_idx   = r_cdepth - CNTW'(1);
    assign s_top   = r_sdepth - CNTW'(1);
    assign s_par   = r_sdepth - CNTW'(2);
    assign cursor  = r_fvalid[r_v] ? {1'b0, f_rd} : r_edges;
    assign descend = (r_state == S_EDGE) && (e_src == r_cv) && ({1'b0, e_dst} < n)
                     && !r_visited[e_dst];
    assign pop_go  = (r_state == S_POP1) && (!r_hvalid || i_out_free);
    assign end_go  = (r_state == S_END) && (!r_hvalid || i_out_free);

    assign vis_raddr = (r_state == S_RET1) ? pv : e_dst;
    assign low_waddr = (r_state == S_ENT1) ? r_v : r_cv;
    assign low_wdata = (r_state == S_ENT1) ? r_nv : r_low;

    assign o_emit.push = (pop_go || end_go) && r_hvalid;
    assign o_emit.last = end_go;
    assign o_emit.res  = r_hold;

    scc_ram #(.WIDTH(2*VW), .DEPTH(MAX_E)) u_edge (
        .i_clk(i_clk), .i_we(acc && !i_cmd && ld_ok), .i_waddr(r_edges[EW-1:0]),
        .i_wdata({i_edge_source, i_edge_target}), .i_raddr(r_e[EW-1:0]), .o_rdata(e_rd)
    );
    scc_ram #(.WIDTH(EW), .DEPTH(MAX_V)) u_first (
        .i_clk(i_clk), .i_we(acc && !i_cmd && ld_ok && new_first), .i_waddr(i_edge_source),
        .i_wdata(r_edges[EW-1:0]), .i_raddr(r_v), .o_rdata(f_rd)
    );
    scc_ram #(.WIDTH(CNTW), .DEPTH(MAX_V)) u_visit (
        .i_clk(i_clk), .i_we(r_state == S_ENT1), .i_waddr(r_v), .i_wdata(r_nv),
        .i_raddr(vis_raddr), .o_rdata(vis_rd)
    );
    scc_ram #(.WIDTH(CNTW), .DEPTH(MAX_V)) u_low (
        .i_clk(i_clk), .i_we((r_state == S_ENT1) || descend), .i_waddr(low_waddr),
        .i_wdata(low_wdata), .i_raddr(pv), .o_rdata(low_rd)
    );
    scc_ram #(.WIDTH(VW), .DEPTH(MAX_V)) u_cstack (
        .i_clk(i_clk), .i_we(r_state == S_ENT1), .i_waddr(r_cdepth[VW-1:0]),
        .i_wdata(r_v), .i_raddr(c_idx[VW-1:0]), .o_rdata(cs_rd)
    );
    scc_ram #(.WIDTH(SSW), .DEPTH(MAX_V)) u_sstack (
        .i_clk(i_clk), .i_we(descend), .i_waddr(s_top[VW-1:0]),
        .i_wdata({r_cv, r_e + ECW'(1)}), .i_raddr(s_par[VW-1:0]), .o_rdata(ss_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_edges    <= '0;
            r_last_src <= '0;
            r_fvalid   <= '0;
            r_visited  <= '0;
            r_onstk    <= '0;
            r_root     <= '0;
            r_sdepth   <= '0;
            r_cdepth   <= '0;
            r_nv       <= CNTW'(1);
            r_pos      <= '0;
            r_comp     <= '0;
            r_hvalid   <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (acc && !i_cmd && ld_ok) begin
                        r_edges    <= r_edges + ECW'(1);
                        r_last_src <= i_edge_source;
                        if (new_first) begin
                            r_fvalid[i_edge_source] <= 1'b1;
                        end
                    end
                    if (acc && i_cmd) begin
                        r_root   <= '0;
                        r_sdepth <= '0;
                        r_cdepth <= '0;
                        r_state  <= S_ROOT;
                    end
                end
                S_ROOT: begin
                    if (r_root >= n) begin
                        r_state <= S_END;
                    end else if (r_visited[r_root[VW-1:0]]) begin
                        r_root <= r_root + CNTW'(1);
                    end else begin
                        r_v     <= r_root[VW-1:0];
                        r_state <= S_ENT0;
                    end
                end
                S_ENT0: r_state <= S_ENT1;
                S_ENT1: begin
                    r_visited[r_v] <= 1'b1;
                    r_onstk[r_v]   <= 1'b1;
                    r_cdepth       <= r_cdepth + CNTW'(1);
                    r_sdepth       <= r_sdepth + CNTW'(1);
                    r_nv           <= r_nv + CNTW'(1);
                    r_cv           <= r_v;
                    r_e            <= cursor;
                    r_vis          <= r_nv;
                    r_low          <= r_nv;
                    r_state        <= S_TOP;
                end
                S_TOP: r_state <= (r_e < r_edges) ? S_EDGE : S_FIN;
                S_EDGE: begin
                    if (e_src != r_cv) begin
                        r_state <= S_FIN;
                    end else begin
                        r_e <= r_e + ECW'(1);
                        if ({1'b0, e_dst} >= n) begin
                            r_state <= S_TOP;
                        end else if (descend) begin
                            r_v     <= e_dst;
                            r_state <= S_ENT0;
                        end else if (r_onstk[e_dst]) begin
                            r_state <= S_VISW;
                        end else begin
                            r_state <= S_TOP;
                        end
                    end
                end
                S_VISW: begin
                    if (vis_rd < r_low) begin
                        r_low <= vis_rd;
                    end
                    r_state <= S_TOP;
                end
                S_FIN: r_state <= (r_low == r_vis) ? S_POP0 : S_RET0;
                S_POP0: r_state <= S_POP1;
                S_POP1: begin
                    if (pop_go) begin
                        r_hvalid                <= 1'b1;
                        r_hold.vertex           <= cs_rd;
                        r_hold.position         <= r_pos[VW-1:0];
                        r_hold.component_number <= r_comp[VW-1:0];
                        r_hold.component_end    <= (cs_rd == r_cv);
                        r_onstk[cs_rd]          <= 1'b0;
                        r_cdepth                <= c_idx;
                        r_pos                   <= r_pos + CNTW'(1);
                        if ((cs_rd != r_cv) && (c_idx != '0)) begin
                            r_state <= S_POP0;
                        end else begin
                            r_comp  <= r_comp + CNTW'(1);
                            r_state <= S_RET0;
                        end
                    end
                end
                S_RET0: begin
                    if (r_sdepth == CNTW'(1)) begin
                        r_sdepth <= '0;
                        r_root   <= r_root + CNTW'(1);
                        r_state  <= S_ROOT;
                    end else begin
                        r_state <= S_RET1;
                    end
                end
                S_RET1: r_state <= S_RET2;
                S_RET2: begin
                    r_cv     <= pv;
                    r_e      <= ss_rd[ECW-1:0];
                    r_vis    <= vis_rd;
                    r_low    <= (low_rd < r_low) ? low_rd : r_low;
                    r_sdepth <= s_top;
                    r_state  <= S_TOP;
                end
                S_END: begin
                    if (end_go) begin
                        r_hvalid   <= 1'b0;
                        r_edges    <= '0;
                        r_last_src <= '0;
                        r_fvalid   <= '0;
                        r_visited  <= '0;
                        r_onstk    <= '0;
                        r_nv       <= CNTW'(1);
                        r_pos      <= '0;
                        r_comp     <= '0;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

FILE: design/strongly_connected_components.sv
// Tarjan strongly connected components. A load word (cmd 0) stores one edge
// and the block is ready again the next cycle. A start word (cmd 1) runs
// the depth-first search in a single sequencer over simple dual-port rams;
// ready stays low until the run ends. Results leave through one output
// register, each word ready for the next cycle; the final word carries last.
// top level: config register and output register, depends on scc_pkg and scc_core
module strongly_connected_components import scc_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [CNTW-1:0] i_cfg_data,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic            i_cmd,
    input  logic [VW-1:0]   i_edge_source,
    input  logic [VW-1:0]   i_edge_target,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [VW-1:0]   o_vertex,
    output logic [VW-1:0]   o_position,
    output logic [VW-1:0]   o_component_number,
    output logic            o_component_end,
    output logic            o_last
);
    logic [CNTW-1:0] r_vcount;
    t_emit           emit;
    logic            out_free;

    assign out_free = !o_valid || i_ready;

    scc_core u_core (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_cmd(i_cmd), .i_edge_source(i_edge_source), .i_edge_target(i_edge_target),
        .i_vcount(r_vcount), .i_out_free(out_free), .o_emit(emit)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount <= '0;
            o_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_vcount <= i_cfg_data;
            end
            if (emit.push) begin
                o_valid <= 1'b1;
            end else if (i_ready) begin
                o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit.push) begin
            o_vertex           <= emit.res.vertex;
            o_position         <= emit.res.position;
            o_component_number <= emit.res.component_number;
            o_component_end    <= emit.res.component_end;
            o_last             <= emit.last;
        end
    end

    // a start word keeps the block busy for at least the next cycle
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_cmd) |=> !o_ready)
        else $error("ready after start word");

    // the final word of a run closes the root component
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |-> o_component_end)
        else $error("last word without component end");

    // no new word while a stalled one waits
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |-> !emit.push)
        else $error("output overrun");
endmodule

FILE: tb/strongly_connected_components_tb.sv
// strongly_connected_components_tb: self-checking bench for the strongly connected
// components block; loads edge lists, starts searches, checks every emitted vertex word
// depends on scc_pkg and strongly_connected_components
module strongly_connected_components_tb;
    import scc_pkg::*;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_START = 1'b1;
    localparam int   WATCHDOG_LIMIT = 20000;

    typedef struct {
        logic          cmd;
        logic [VW-1:0] src;
        logic [VW-1:0] dst;
    } t_in_word;

    typedef struct {
        logic [VW-1:0] vertex;
        logic [VW-1:0] position;
        logic [VW-1:0] comp;
        logic          cend;
        logic          last;
    } t_out_word;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            i_cfg_we = 1'b0;
    logic [CNTW-1:0] i_cfg_data = '0;
    logic            i_valid = 1'b0;
    logic            o_ready;
    logic            i_cmd = 1'b0;
    logic [VW-1:0]   i_edge_source = '0;
    logic [VW-1:0]   i_edge_target = '0;
    logic            o_valid;
    logic            i_ready = 1'b0;
    logic [VW-1:0]   o_vertex;
    logic [VW-1:0]   o_position;
    logic [VW-1:0]   o_component_number;
    logic            o_component_end;
    logic            o_last;

    strongly_connected_components u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_data         (i_cfg_data),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_cmd              (i_cmd),
        .i_edge_source      (i_edge_source),
        .i_edge_target      (i_edge_target),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_vertex           (o_vertex),
        .o_position         (o_position),
        .o_component_number (o_component_number),
        .o_component_end    (o_component_end),
        .o_last             (o_last)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    t_in_word     pending_q[$];
    t_out_word    order_q[$];
    int           errors = 0;
    int           tx_idle = 0;
    int           rx_idle = 0;
    int           rx_hold = 0;
    int           items_sent = 0;
    bit           word_taken = 0;
    bit           run_done = 0;

    // predictor state
    int cfg_count = 0;
    int edge_src[MAX_E];
    int edge_dst[MAX_E];
    int n_edges;
    int first_edge[MAX_V];
    bit first_ok[MAX_V];
    int visit[MAX_V];
    int low[MAX_V];
    bit on_stack[MAX_V];
    int comp_stack[MAX_V];
    int walk_vertex[MAX_V];
    int walk_cursor[MAX_V];
    int next_visit, out_pos, comps, sdepth, cdepth;

    function automatic int active_n();
        return (cfg_count > MAX_V) ? MAX_V : cfg_count;
    endfunction

    function automatic void clear_search();
        n_edges = 0;
        next_visit = 1;
        out_pos = 0;
        comps = 0;
        for (int i = 0; i < MAX_V; i++) begin
            first_edge[i] = 0;
            first_ok[i] = 0;
            visit[i] = 0;
            low[i] = 0;
            on_stack[i] = 0;
        end
    endfunction

    function automatic void store_edge(int s, int d);
        int n;
        n = active_n();
        if (n_edges >= MAX_E || s >= n || d >= n) return;
        if (n_edges > 0 && s < edge_src[n_edges-1]) return;
        if (n_edges == 0 || s != edge_src[n_edges-1]) begin
            first_edge[s] = n_edges;
            first_ok[s] = 1;
        end
        edge_src[n_edges] = s;
        edge_dst[n_edges] = d;
        n_edges++;
    endfunction

    function automatic void enter_vertex(int v);
        visit[v] = next_visit;
        low[v] = next_visit;
        next_visit++;
        on_stack[v] = 1;
        comp_stack[cdepth] = v;
        cdepth++;
        walk_vertex[sdepth] = v;
        walk_cursor[sdepth] = first_ok[v] ? first_edge[v] : n_edges;
        sdepth++;
    endfunction

    function automatic void predict_order();
        int n, cv, e, w, cnt;
        t_out_word r;
        n = active_n();
        cnt = 0;
        sdepth = 0;
        cdepth = 0;
        for (int root = 0; root < n; root++) begin
            if (visit[root] != 0) continue;
            enter_vertex(root);
            while (sdepth > 0) begin
                cv = walk_vertex[sdepth-1];
                e = walk_cursor[sdepth-1];
                if (e < n_edges && edge_src[e] == cv) begin
                    w = edge_dst[e];
                    walk_cursor[sdepth-1] = e + 1;
                    if (w < n) begin
                        if (visit[w] == 0) enter_vertex(w);
                        else if (on_stack[w] && visit[w] < low[cv]) low[cv] = visit[w];
                    end
                end else begin
                    if (low[cv] == visit[cv]) begin
                        do begin
                            cdepth--;
                            w = comp_stack[cdepth];
                            on_stack[w] = 0;
                            r.vertex = w[VW-1:0];
                            r.position = out_pos[VW-1:0];
                            r.comp = comps[VW-1:0];
                            r.cend = (w == cv);
                            r.last = 1'b0;
                            order_q.push_back(r);
                            out_pos++;
                            cnt++;
                        end while (w != cv && cdepth > 0);
                        comps++;
                    end
                    sdepth--;
                    if (sdepth > 0 && low[cv] < low[walk_vertex[sdepth-1]])
                        low[walk_vertex[sdepth-1]] = low[cv];
                end
            end
        end
        if (cnt > 0) order_q[order_q.size()-1].last = 1'b1;
        clear_search();
    endfunction

    // input side: acceptance, prediction, output checking, watchdog
    int quiet_cycles = 0;
    always @(posedge i_clk) begin
        bit moved;
        t_out_word x;
        moved = 0;
        if (i_rst_n && i_valid && o_ready) begin
            moved = 1;
            word_taken = 1;
            if (i_cmd == CMD_START) predict_order();
            else store_edge(i_edge_source, i_edge_target);
        end
        if (i_rst_n && o_valid && i_ready) begin
            moved = 1;
            if (order_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected word vertex %0d", $time, o_vertex);
            end else begin
                x = order_q.pop_front();
                if (o_vertex !== x.vertex || o_position !== x.position
                    || o_component_number !== x.comp || o_component_end !== x.cend
                    || o_last !== x.last) begin
                    errors++;
                    $display({"%0t: mismatch expected v%0d p%0d c%0d e%0d l%0d",
                              " got v%0d p%0d c%0d e%0d l%0d"},
                             $time, x.vertex, x.position, x.comp, x.cend, x.last,
                             o_vertex, o_position, o_component_number, o_component_end,
                             o_last);
                end
            end
        end
        quiet_cycles = moved ? 0 : quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT && !run_done) begin
            $display("strongly_connected_components regression: fail");
            $finish;
        end
    end

    // driver
    always @(negedge i_clk) begin
        t_in_word d;
        if (i_rst_n && (!i_valid || word_taken)) begin
            word_taken = 0;
            if (pending_q.size() > 0 && $urandom_range(99) >= tx_idle) begin
                d = pending_q.pop_front();
                i_cmd <= d.cmd;
                i_edge_source <= d.src;
                i_edge_target <= d.dst;
                i_valid <= 1'b1;
                items_sent++;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver
    always @(negedge i_clk) begin
        if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= i_rst_n && ($urandom_range(99) >= rx_idle);
        end
    end

    task automatic push_word(logic c, int s, int d);
        t_in_word w;
        w.cmd = c;
        w.src = s[VW-1:0];
        w.dst = d[VW-1:0];
        pending_q.push_back(w);
    endtask

    task automatic drain();
        while (pending_q.size() > 0 || i_valid || order_q.size() > 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic set_vertex_count(int v);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= v[CNTW-1:0];
        @(posedge i_clk);
        cfg_count = v & 8'h7f;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // random graph on n vertices, sorted sources, some noise
    task automatic push_graph(int n, int ne, int noise_pct);
        int srcs[$];
        int lim;
        lim = (n == 0) ? 1 : n;
        for (int i = 0; i < ne; i++) srcs.push_back($urandom_range(lim - 1));
        srcs.sort();
        foreach (srcs[i]) begin
            if ($urandom_range(99) < noise_pct)
                push_word(CMD_LOAD, $urandom_range(63), $urandom_range(63));
            else
                push_word(CMD_LOAD, srcs[i], $urandom_range(lim - 1));
        end
    endtask

    initial begin
        int n;
        clear_search();
        tx_idle = 30;
        rx_idle = 59;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed
        set_vertex_count(8);
        push_word(CMD_LOAD, 0, 1);
        push_word(CMD_LOAD, 1, 2);
        push_word(CMD_LOAD, 2, 0);
        push_word(CMD_LOAD, 2, 9);
        push_word(CMD_LOAD, 1, 3);
        push_word(CMD_LOAD, 3, 3);
        push_word(CMD_LOAD, 4, 5);
        push_word(CMD_LOAD, 5, 4);
        push_word(CMD_LOAD, 7, 6);
        push_word(CMD_START, 0, 0);
        drain();
        set_vertex_count(0);
        push_word(CMD_LOAD, 0, 0);
        push_word(CMD_START, 63, 63);
        drain();
        set_vertex_count(10);
        push_word(CMD_LOAD, 0, 9);
        push_word(CMD_LOAD, 3, 4);
        push_word(CMD_LOAD, 4, 3);
        push_word(CMD_LOAD, 9, 0);
        drain();
        set_vertex_count(5);
        push_word(CMD_START, 0, 0);
        drain();
        set_vertex_count(64);
        push_word(CMD_LOAD, 0, 63);
        push_word(CMD_LOAD, 63, 0);
        push_word(CMD_LOAD, 63, 63);
        push_word(CMD_START, 0, 0);
        drain();

        // full store, then long receiver hold while more words queue up
        set_vertex_count(64);
        push_graph(64, 270, 0);
        push_word(CMD_START, 0, 0);
        push_graph(64, 20, 0);
        push_word(CMD_START, 0, 0);
        while (pending_q.size() > 21) @(posedge i_clk);
        rx_hold = 3000;
        drain();

        for (int ph = 0; items_sent < 500; ph++) begin
            if (items_sent < 380) begin
                tx_idle = 30;
                rx_idle = 59;
            end else if (items_sent < 440) begin
                tx_idle = 59;
                rx_idle = 30;
            end else begin
                tx_idle = 0;
                rx_idle = 0;
            end
            case ($urandom_range(9))
                0: n = 64;
                1: n = 0;
                default: n = $urandom_range(12, 1);
            endcase
            set_vertex_count(n);
            push_graph(n, $urandom_range(2 * n + 2), ($urandom_range(3) == 0) ? 20 : 0);
            push_word(CMD_START, $urandom_range(63), $urandom_range(63));
            drain();
        end
        run_done = 1;
        if (errors == 0) $display("strongly_connected_components regression: pass");
        else $display("strongly_connected_components regression: fail");
        $finish;
    end
endmodule
